// ----- design/prru_pkg.sv -----
`default_nettype none

package prru_pkg;

	localparam int MAX_TAPS      = 256;
	localparam int HISTORY_DEPTH = 256;
	localparam int MAX_FACTOR    = 64;

	localparam int SAMPLE_W   = 16;
	localparam int FACTOR_W   = 7;
	localparam int TAPCNT_W   = 9;
	localparam int COEF_IDX_W = 8;
	localparam int ACC_W      = 48;
	localparam int SCALED_W   = ACC_W + FACTOR_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam int TAP_AW  = $clog2(MAX_TAPS);
	localparam int HIST_AW = $clog2(HISTORY_DEPTH);
	// Tap walk index: reaches the tap count plus one interpolation step.
	localparam int K_W     = $clog2(MAX_TAPS + MAX_FACTOR);

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COEF   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERP = 2'd0,
		REG_DECIM  = 2'd1,
		REG_TAPS   = 2'd2
	} cfg_reg_t;

	function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
		logic [FACTOR_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = FACTOR_W'(1);
		end else if (int'(v) > MAX_FACTOR) begin
			r = FACTOR_W'(MAX_FACTOR);
		end
		return r;
	endfunction

	function automatic logic [K_W-1:0] clamp_taps(input logic [TAPCNT_W-1:0] v);
		logic [K_W-1:0] r;
		r = K_W'(v);
		if (v == '0) begin
			r = K_W'(1);
		end else if (int'(v) > MAX_TAPS) begin
			r = K_W'(MAX_TAPS);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/polyphase_rational_resampler_unit.sv -----
// Each output is computed by the single multiply-accumulate unit, which reads one
// coefficient and one history word a cycle while it walks the taps of the current phase.
// A coefficient transfer does not stall the input; a sample stalls it until every
// output of that sample has been loaded and the block is idle again.
// Reset (asynchronous, active low) restores L = 1, M = 1, 256 taps and phase zero; the
// history reads as zero until written, tracked by a fill pointer, so no clearing pass runs.
`default_nettype none

module polyphase_rational_resampler_unit
	import prru_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,

	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         kind,
	input  wire logic signed [SAMPLE_W-1:0]   sample_in,
	input  wire logic [COEF_IDX_W-1:0]        coef_index,
	input  wire logic signed [SAMPLE_W-1:0]   coef_value,

	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [SAMPLE_W-1:0]        sample_out,
	output logic                              last_in_run
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_DRAIN,
		ST_SCALE,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [FACTOR_W-1:0]   interp_q;
	logic [FACTOR_W-1:0]   decim_q;
	logic [TAPCNT_W-1:0]   taps_raw_q;

	logic [FACTOR_W-1:0]   l_q;
	logic [FACTOR_W-1:0]   m_q;
	logic [K_W-1:0]        taps_q;
	logic [FACTOR_W-1:0]   phase_q;
	logic [HIST_AW-1:0]    wp_q;
	logic                  wrapped_q;
	logic [HIST_AW-1:0]    newest_q;
	logic [K_W-1:0]        k_q;
	logic [HIST_AW-1:0]    j_q;

	logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];

	logic signed [SAMPLE_W-1:0]   coef_rd_s1;
	logic signed [SAMPLE_W-1:0]   hist_rd_s1;
	logic                         hist_ok_s1;
	logic                         rd_v_s1;
	logic signed [2*SAMPLE_W-1:0] prod_s2;
	logic                         prod_v_s2;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [SCALED_W-1:0]   scaled_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_W-1:0]    sample_out_q;
	logic                          last_q;

	logic                          in_accept;
	logic                          coef_we;
	logic                          hist_we;
	logic                          issue;
	logic                          hist_ok;
	logic [HIST_AW-1:0]            wp_next;
	logic [HIST_AW-1:0]            j_prev;
	logic                          out_free;
	logic [FACTOR_W-1:0]           phase_next;
	logic                          last_now;
	logic signed [ACC_W-1:0]       sat_acc;
	logic signed [ACC_W:0]         rounded;
	logic signed [ACC_W-15:0]      quot;
	logic signed [SAMPLE_W-1:0]    result;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign coef_we     = in_accept && (kind == KIND_COEF) && (int'(coef_index) < MAX_TAPS);
	assign hist_we     = in_accept && (kind == KIND_SAMPLE);

	assign wp_next = (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + HIST_AW'(1);
	assign j_prev  = (j_q == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : j_q - HIST_AW'(1);

	assign issue   = (state_q == ST_ISSUE) && (k_q < taps_q);
	// Entries at or beyond the fill pointer have never been written until the first wrap.
	assign hist_ok = wrapped_q || (j_q < wp_q);

	assign out_free   = !out_valid_q || !out_stall;
	assign phase_next = phase_q + m_q;
	assign last_now   = (phase_next >= l_q);

	always_comb begin
		sat_acc = scaled_q[ACC_W-1:0];
		if (scaled_q[SCALED_W-1:ACC_W-1] != '0 && scaled_q[SCALED_W-1:ACC_W-1] != '1) begin
			sat_acc = scaled_q[SCALED_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
			                               : {1'b0, {(ACC_W-1){1'b1}}};
		end
		rounded = {sat_acc[ACC_W-1], sat_acc} + (ACC_W+1)'(16384);
		quot    = rounded[ACC_W:15];
		result  = quot[SAMPLE_W-1:0];
		if (quot[ACC_W-15:SAMPLE_W-1] != '0 && quot[ACC_W-15:SAMPLE_W-1] != '1) begin
			result = quot[ACC_W-15] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q   <= FACTOR_W'(1);
			decim_q    <= FACTOR_W'(1);
			taps_raw_q <= TAPCNT_W'(256);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_INTERP: interp_q   <= cfg_wdata[FACTOR_W-1:0];
				REG_DECIM:  decim_q    <= cfg_wdata[FACTOR_W-1:0];
				REG_TAPS:   taps_raw_q <= cfg_wdata[TAPCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[TAP_AW'(coef_index)] <= coef_value;
		end
		if (hist_we) begin
			hist_mem[wp_q] <= sample_in;
		end
		coef_rd_s1 <= coef_mem[k_q[TAP_AW-1:0]];
		hist_rd_s1 <= hist_mem[j_q];
		hist_ok_s1 <= hist_ok;
		prod_s2    <= coef_rd_s1 * (hist_ok_s1 ? hist_rd_s1 : SAMPLE_W'(0));
		if (state_q == ST_CHECK) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= acc_q * $signed({1'b0, l_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			rd_v_s1   <= issue;
			prod_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			l_q          <= FACTOR_W'(1);
			m_q          <= FACTOR_W'(1);
			taps_q       <= K_W'(1);
			phase_q      <= '0;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			newest_q     <= '0;
			k_q          <= '0;
			j_q          <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (hist_we) begin
						newest_q <= wp_q;
						wp_q     <= wp_next;
						if (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) begin
							wrapped_q <= 1'b1;
						end
						l_q     <= clamp_factor(interp_q);
						m_q     <= clamp_factor(decim_q);
						taps_q  <= clamp_taps(taps_raw_q);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (phase_q < l_q) begin
						k_q     <= K_W'(phase_q);
						j_q     <= newest_q;
						state_q <= ST_ISSUE;
					end else begin
						phase_q <= phase_q - l_q;
						state_q <= ST_IDLE;
					end
				end
				ST_ISSUE: begin
					if (issue) begin
						k_q <= k_q + K_W'(l_q);
						j_q <= j_prev;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !prod_v_s2) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						sample_out_q <= result;
						last_q       <= last_now;
						phase_q      <= phase_next;
						state_q      <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign last_in_run = last_q;

	// The phase left over after a run is below M, so it never reaches 64 between samples.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> phase_q < FACTOR_W'(MAX_FACTOR))
		else $error("phase register out of range");

	// The sum is scaled only once every product has reached the accumulator.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE |-> !rd_v_s1 && !prod_v_s2)
		else $error("scaling started with products still in flight");

	// Memory reads enter the pipeline only from the tap walk.
	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q == ST_ISSUE))
		else $error("read issued outside the tap walk");

	// A new result is loaded only when the previous one has been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(sample_out_q) && $stable(last_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- tb/sv/prru_output_checker.sv -----
module prru_output_checker
	import prru_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic                       kind,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic [COEF_IDX_W-1:0]      coef_index,
	input  wire logic signed [SAMPLE_W-1:0] coef_value,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample_out,
	input  wire logic                       last_in_run,
	output int                              mismatches,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} out_word_t;

	out_word_t due_q[$];

	logic [FACTOR_W-1:0]        interp_r;
	logic [FACTOR_W-1:0]        decim_r;
	logic [TAPCNT_W-1:0]        taps_r;
	logic [FACTOR_W-1:0]        phase_r;
	int                         wr_ptr;
	logic signed [SAMPLE_W-1:0] hist [HISTORY_DEPTH];
	logic signed [SAMPLE_W-1:0] coef_tab [MAX_TAPS];

	function automatic int clamp_to(input int v, input int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint clip_acc(input longint v);
		if (v > ACC_TOP) return ACC_TOP;
		if (v < -ACC_TOP - 1) return -ACC_TOP - 1;
		return v;
	endfunction

	// Stores the sample and queues every output it produces at the current phase.
	task automatic resample_sample(input logic signed [SAMPLE_W-1:0] s);
		int        l_eff;
		int        m_eff;
		int        t_eff;
		int        newest;
		int        ph;
		int        n;
		int        j;
		int        k;
		longint    acc;
		longint    q;
		out_word_t w;
		l_eff = clamp_to(int'(interp_r), MAX_FACTOR);
		m_eff = clamp_to(int'(decim_r), MAX_FACTOR);
		t_eff = clamp_to(int'(taps_r), MAX_TAPS);
		newest = wr_ptr;
		hist[newest] = s;
		wr_ptr = (newest + 1) % HISTORY_DEPTH;
		ph = int'(phase_r);
		n = 0;
		while (ph < l_eff && n < MAX_FACTOR) begin
			acc = 0;
			j = newest;
			for (k = ph; k < t_eff; k += l_eff) begin
				acc += longint'(coef_tab[k]) * longint'(hist[j]);
				j = (j + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
			end
			acc = clip_acc(clip_acc(acc) * l_eff);
			// Round half up, then floor back to Q1.15.
			q = (acc + 16384) >>> 15;
			if (q > 32767) q = 32767;
			else if (q < -32768) q = -32768;
			w.value = q[SAMPLE_W-1:0];
			w.last = !((ph + m_eff < l_eff) && (n + 1 < MAX_FACTOR));
			due_q.push_back(w);
			n++;
			ph += m_eff;
		end
		ph = (ph >= l_eff) ? ph - l_eff : 0;
		phase_r = ph[FACTOR_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t head;
		int        i;
		if (!arst_n) begin
			interp_r = FACTOR_W'(1);
			decim_r = FACTOR_W'(1);
			taps_r = TAPCNT_W'(MAX_TAPS);
			phase_r = '0;
			wr_ptr = 0;
			for (i = 0; i < HISTORY_DEPTH; i++) hist[i] = '0;
			for (i = 0; i < MAX_TAPS; i++) coef_tab[i] = '0;
			due_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_INTERP: interp_r = cfg_wdata[FACTOR_W-1:0];
					REG_DECIM:  decim_r = cfg_wdata[FACTOR_W-1:0];
					REG_TAPS:   taps_r = cfg_wdata[TAPCNT_W-1:0];
					default: ;
				endcase
			end
			// Outputs are checked before this edge's input is predicted, so that an
			// output arriving with nothing due cannot be matched to a later sample.
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					$display("%0t: unexpected output transfer, sample_out %0d last_in_run %0b",
						$time, sample_out, last_in_run);
					mismatches++;
				end else begin
					head = due_q.pop_front();
					if (sample_out !== head.value) begin
						$display("%0t: sample_out expected %0d, got %0d",
							$time, head.value, sample_out);
					end
					if (last_in_run !== head.last) begin
						$display("%0t: last_in_run expected %0b, got %0b",
							$time, head.last, last_in_run);
					end
					if (sample_out !== head.value || last_in_run !== head.last) mismatches++;
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_COEF) coef_tab[coef_index] = coef_value;
				else resample_sample(sample_in);
			end
			pending = due_q.size();
		end
	end

endmodule

// ----- tb/sv/polyphase_rational_resampler_unit_tb.sv -----
module polyphase_rational_resampler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prru_pkg::*;

	localparam int ITEM_GOAL     = 410;
	localparam int IDLE_MAX      = 11;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 5000;

	localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_INTERP;
	logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       kind = KIND_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic [COEF_IDX_W-1:0]      coef_index = '0;
	logic signed [SAMPLE_W-1:0] coef_value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       last_in_run;
	int                         mismatches;
	int                         pending;

	int items_sent = 0;
	int coef_writes = 0;
	int results_seen = 0;
	int settings_used = 0;
	int in_calm = 0;
	int out_calm = 0;
	bit coef_seen [MAX_TAPS];

	always #1 clk = ~clk;

	polyphase_rational_resampler_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.sample_in   (sample_in),
		.coef_index  (coef_index),
		.coef_value  (coef_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.last_in_run (last_in_run)
	);

	prru_output_checker out_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.sample_in   (sample_in),
		.coef_index  (coef_index),
		.coef_value  (coef_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.last_in_run (last_in_run),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	// Idle cycles before the next transfer, with occasional stretches of none at all.
	task automatic draw_idle(inout int calm_left, output int cycles);
		if (calm_left > 0) begin
			calm_left--;
			cycles = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 30);
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, IDLE_MAX);
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_q15(input int max_shift);
		logic signed [SAMPLE_W-1:0] v;
		case ($urandom_range(0, 11))
			0: v = Q15_MAX;
			1: v = Q15_MIN;
			default: begin
				v = SAMPLE_W'($urandom);
				v = v >>> $urandom_range(0, max_shift);
			end
		endcase
		return v;
	endfunction

	task automatic push_item(input logic k, input logic signed [SAMPLE_W-1:0] s,
			input logic [COEF_IDX_W-1:0] ci, input logic signed [SAMPLE_W-1:0] cv);
		int gap;
		draw_idle(in_calm, gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= k;
		sample_in <= s;
		coef_index <= ci;
		coef_value <= cv;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (k == KIND_COEF) begin
			coef_seen[ci] = 1'b1;
			coef_writes++;
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		push_item(KIND_SAMPLE, s, COEF_IDX_W'($urandom), rand_q15(0));
	endtask

	task automatic send_coef(input logic [COEF_IDX_W-1:0] ci,
			input logic signed [SAMPLE_W-1:0] cv);
		push_item(KIND_COEF, rand_q15(0), ci, cv);
	endtask

	// Stops offering and waits until every predicted output has been transferred,
	// then lets a tap-table write or a silent sample finish inside the block.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// New rate setting on an idle block; taps that will be read are loaded first.
	task automatic apply_setting(input int l_raw, input int m_raw, input int t_raw);
		int need;
		int i;
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_INTERP;
		cfg_wdata <= CFG_DATA_W'(l_raw);
		@(posedge clk);
		cfg_index <= REG_DECIM;
		cfg_wdata <= CFG_DATA_W'(m_raw);
		@(posedge clk);
		cfg_index <= REG_TAPS;
		cfg_wdata <= CFG_DATA_W'(t_raw);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		need = (t_raw == 0) ? 1 : ((t_raw > MAX_TAPS) ? MAX_TAPS : t_raw);
		for (i = 0; i < need; i++) begin
			if (!coef_seen[i]) send_coef(COEF_IDX_W'(i), rand_q15(5));
		end
		settings_used++;
	endtask

	initial begin : stimulus
		int setting_idx;
		int count;
		int l_raw;
		int m_raw;
		int t_raw;
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-scale taps so that both saturation limits are reached.
		for (i = 0; i < 8; i++) send_coef(COEF_IDX_W'(i), Q15_MAX);
		send_coef(COEF_IDX_W'(MAX_TAPS - 1), Q15_MIN);
		apply_setting(1, 1, 8);
		send_sample(Q15_MAX);
		send_sample(Q15_MAX);
		send_sample(Q15_MIN);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(Q15_MIN);
		send_sample(Q15_MAX);
		send_coef(COEF_IDX_W'(3), Q15_MIN);
		send_coef(COEF_IDX_W'(0), 16'sd0);
		send_sample(Q15_MIN);
		send_sample(Q15_MAX);

		setting_idx = 0;
		while (items_sent < ITEM_GOAL) begin
			case (setting_idx)
				// Zero in every register: all three are taken as one.
				0: begin l_raw = 0;   m_raw = 0;   t_raw = 0;   count = 8;  end
				1: begin l_raw = 3;   m_raw = 2;   t_raw = 24;  count = 16; end
				// Largest L with unit M: a full run of outputs per sample.
				2: begin l_raw = 64;  m_raw = 1;   t_raw = 64;  count = 3;  end
				// Over-range L and tap count; the whole tap table gets loaded here.
				3: begin l_raw = 100; m_raw = 64;  t_raw = 300; count = 10; end
				4: begin l_raw = 261; m_raw = 3;   t_raw = 40;  count = 16; end
				5: begin l_raw = 1;   m_raw = 5;   t_raw = 256; count = 24; end
				// Fewer taps than phases, so most phases sum nothing.
				6: begin l_raw = 7;   m_raw = 10;  t_raw = 1;   count = 16; end
				7: begin l_raw = 2;   m_raw = 511; t_raw = 511; count = 12; end
				default: begin
					l_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
						: $urandom_range(1, MAX_FACTOR);
					m_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
						: $urandom_range(1, MAX_FACTOR);
					t_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
						: $urandom_range(1, 64);
					count = $urandom_range(8, 40);
				end
			endcase
			apply_setting(l_raw, m_raw, t_raw);
			repeat (count) begin
				if ($urandom_range(0, 7) == 0) send_coef(COEF_IDX_W'($urandom), rand_q15(5));
				else send_sample(rand_q15(0));
			end
			setting_idx++;
		end

		drain_results();
		$display("Covered %0d input transfers (%0d tap writes) and %0d outputs", items_sent,
			coef_writes, results_seen);
		$display("over %0d rate settings, including clamped factors and 1 to 256 taps.",
			settings_used);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Output: random back-pressure; per 250 results, a long hold-off fills the block.
	initial begin : receiver
		int hold;
		@(posedge arst_n);
		forever begin
			draw_idle(out_calm, hold);
			if (results_seen % 250 == HOLD_AT) hold = HOLD_CYCLES;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
design/prru_pkg.sv
design/polyphase_rational_resampler_unit.sv
tb/sv/prru_output_checker.sv
tb/sv/polyphase_rational_resampler_unit_tb.sv
